>>> sv/rcpt_pkg.sv
package rcpt_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_APPLY = 2'd3
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // add_status codes
    localparam logic [2:0] ADD_OK       = 3'd0;
    localparam logic [2:0] ADD_TOGGLED  = 3'd1;
    localparam logic [2:0] ADD_BAD_LEN  = 3'd2;
    localparam logic [2:0] ADD_FULL     = 3'd3;
    localparam logic [2:0] ADD_BAD_TYPE = 3'd4;
    localparam logic [2:0] ADD_NONE     = 3'd5;

    // entry kinds; write_kind is kind minus one
    localparam logic [1:0] KIND_ROM   = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_SRAM  = 2'd2;
    localparam logic [1:0] KIND_WRAM  = 2'd3;

    localparam logic [3:0] LEN_ROM_SHORT = 4'd6;
    localparam logic [3:0] LEN_RAM       = 4'd8;
    localparam logic [3:0] LEN_ROM_LONG  = 4'd9;

    localparam logic [7:0]  TT_PLAIN      = 8'h01;
    localparam logic [3:0]  TT_SRAM       = 4'h8;
    localparam logic [3:0]  TT_WRAM       = 4'h9;
    localparam logic [15:0] ADDR_SCRAMBLE = 16'hF000;
    localparam logic [7:0]  CMP_INVERT    = 8'hFF;
    localparam logic [7:0]  CMP_XOR       = 8'h45;

    localparam int MAX_RESULTS = 32;
    localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  bank;
        logic        active;
        logic [15:0] addr;
        logic [7:0]  new_val;
        logic [7:0]  cmp_val;
        logic        has_cmp;
    } entry_t;

    typedef struct packed {
        logic [39:0] key;   // length in 39:36, used digits in 35:0
        entry_t      ent;
    } row_t;

endpackage

>>> sv/rom_read_cheat_patch_table.sv
// channel | signals                                              | dir
// --------+------------------------------------------------------+----
// in      | in_valid in_stall cmd code_digits code_len address   | in
//         | rom_data                                             |
// out     | out_valid out_stall read_data add_status write_valid | out
//         | write_kind write_bank write_addr write_value last    |
//
// One item at a time. An add, read or apply walks the table through the
// single read port of the table RAM, one entry per cycle while no write beat
// waits. Clear and an add with a bad length finish without a walk. Add and
// read stop early on a hit.
// rst_n clears control and the entry count; the table RAM is not cleared.
// out_stall holds the output register; the walk pauses while a write beat
// waits. in_stall is high while an item is in work.
module rom_read_cheat_patch_table
    import rcpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int ROM_ADDR_BITS = 23
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic [35:0]              code_digits,
    input  logic [3:0]               code_len,
    input  logic [ROM_ADDR_BITS-1:0] address,
    input  logic [7:0]               rom_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               read_data,
    output logic [2:0]               add_status,
    output logic                     write_valid,
    output logic [1:0]               write_kind,
    output logic [3:0]               write_bank,
    output logic [15:0]              write_addr,
    output logic [7:0]               write_value,
    output logic                     last
);

    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int IXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // table RAM
    row_t mem [TABLE_ENTRIES];
    row_t rd_data_reg;
    logic rd_en;
    logic [IXW-1:0] rd_addr;
    logic wr_en;
    logic [IXW-1:0] wr_addr;
    row_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic skip_reg, skip_next;
    logic badtype_reg, badtype_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic pend_reg, pend_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic held_valid_reg, held_valid_next;
    logic out_valid_reg, out_valid_next;

    // payload registers
    logic [39:0] key_reg, key_next;
    entry_t newent_reg, newent_next;
    logic [14:0] vaddr_reg, vaddr_next;
    logic [7:0] data_reg, data_next;
    logic [IXW-1:0] eidx_reg, eidx_next;
    entry_t held_reg, held_next;
    logic [7:0] o_read_data_reg, o_read_data_next;
    logic [2:0] o_status_reg, o_status_next;
    logic o_wv_reg, o_wv_next;
    logic [1:0] o_kind_reg, o_kind_next;
    logic [3:0] o_bank_reg, o_bank_next;
    logic [15:0] o_addr_reg, o_addr_next;
    logic [7:0] o_value_reg, o_value_next;
    logic o_last_reg, o_last_next;

    // code decode
    logic [35:0] masked;
    logic len_ok;
    logic bad_type;
    entry_t dec;
    logic [7:0] tt;
    logic [7:0] g;

    always_comb
    begin
        len_ok = (code_len == LEN_ROM_SHORT) || (code_len == LEN_RAM) ||
                 (code_len == LEN_ROM_LONG);
        if (code_len == LEN_ROM_SHORT)
        begin
            masked = {code_digits[35:12], 12'h000};
        end
        else if (code_len == LEN_RAM)
        begin
            masked = {code_digits[35:4], 4'h0};
        end
        else
        begin
            masked = code_digits;
        end
        tt = masked[35:28];
        g = {masked[11:8], masked[3:0]} ^ CMP_INVERT;
        bad_type = 1'b0;
        dec = '0;
        dec.active = 1'b1;
        if (code_len == LEN_RAM)
        begin
            dec.new_val = masked[27:20];
            dec.addr = {masked[11:4], masked[19:12]};
            if (tt == TT_PLAIN)
            begin
                dec.kind = KIND_PLAIN;
            end
            else if (tt[7:4] == TT_SRAM)
            begin
                dec.kind = KIND_SRAM;
                dec.bank = tt[3:0];
            end
            else if (tt[7:4] == TT_WRAM)
            begin
                dec.kind = KIND_WRAM;
                dec.bank = tt[3:0];
            end
            else
            begin
                bad_type = 1'b1;
            end
        end
        else
        begin
            dec.kind = KIND_ROM;
            dec.new_val = masked[35:28];
            dec.addr = {masked[15:12], masked[27:16]} ^ ADDR_SCRAMBLE;
            if (code_len == LEN_ROM_LONG)
            begin
                dec.cmp_val = {g[1:0], g[7:2]} ^ CMP_XOR;
                dec.has_cmp = 1'b1;
            end
        end
    end

    // scan evaluation
    row_t e;
    logic out_free;
    logic key_hit;
    logic rom_hit;
    logic wr_hit;
    logic more;
    logic scan_done;

    always_comb
    begin
        e = rd_data_reg;
        out_free = !out_valid_reg || !out_stall;
        key_hit = pend_reg && (e.key == key_reg);
        rom_hit = pend_reg && (e.ent.kind == KIND_ROM) && e.ent.active &&
                  (e.ent.addr == {1'b0, vaddr_reg}) &&
                  (!e.ent.has_cmp || (e.ent.cmp_val == data_reg));
        wr_hit = pend_reg && e.ent.active && (e.ent.kind != KIND_ROM);
        more = idx_reg < count_reg;
        scan_done = skip_reg || (!pend_reg && !more) ||
                    ((cmd_reg == CMD_APPLY) && (found_reg == FOUND_W'(MAX_RESULTS)));
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        skip_next = skip_reg;
        badtype_next = badtype_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        pend_next = pend_reg;
        found_next = found_reg;
        held_valid_next = held_valid_reg;
        key_next = key_reg;
        newent_next = newent_reg;
        vaddr_next = vaddr_reg;
        data_next = data_reg;
        eidx_next = eidx_reg;
        held_next = held_reg;
        rd_en = 1'b0;
        rd_addr = idx_reg[IXW-1:0];
        wr_en = 1'b0;
        wr_addr = eidx_reg;
        wr_data = e;
        out_valid_next = out_valid_reg && out_stall;
        o_read_data_next = o_read_data_reg;
        o_status_next = o_status_reg;
        o_wv_next = o_wv_reg;
        o_kind_next = o_kind_reg;
        o_bank_next = o_bank_reg;
        o_addr_next = o_addr_reg;
        o_value_next = o_value_reg;
        o_last_next = o_last_reg;
        in_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd_t'(cmd);
                    skip_next = (cmd_t'(cmd) == CMD_ADD) && !len_ok;
                    badtype_next = bad_type;
                    key_next = {code_len, masked};
                    newent_next = dec;
                    vaddr_next = {|address[ROM_ADDR_BITS-1:14], address[13:0]};
                    data_next = rom_data;
                    idx_next = '0;
                    pend_next = 1'b0;
                    found_next = '0;
                    held_valid_next = 1'b0;
                    if (cmd_t'(cmd) == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one result beat: start from a blank record, but never under a waiting beat
                if (out_free)
                begin
                    o_read_data_next = 8'h00;
                    o_status_next = ADD_NONE;
                    o_wv_next = 1'b0;
                    o_kind_next = 2'd0;
                    o_bank_next = 4'h0;
                    o_addr_next = 16'h0000;
                    o_value_next = 8'h00;
                    o_last_next = 1'b1;
                end
                priority if ((cmd_reg == CMD_ADD) && key_hit && !skip_reg)
                begin
                    if (out_free)
                    begin
                        wr_en = 1'b1;
                        wr_data.ent.active = !e.ent.active;
                        o_status_next = ADD_TOGGLED;
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if ((cmd_reg == CMD_READ) && rom_hit)
                begin
                    if (out_free)
                    begin
                        o_read_data_next = e.ent.new_val;
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (scan_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                        held_valid_next = 1'b0;
                        unique case (cmd_reg)
                            CMD_ADD:
                            begin
                                priority if (skip_reg)
                                begin
                                    o_status_next = ADD_BAD_LEN;
                                end
                                else if (count_reg == CW'(TABLE_ENTRIES))
                                begin
                                    o_status_next = ADD_FULL;
                                end
                                else if (badtype_reg)
                                begin
                                    o_status_next = ADD_BAD_TYPE;
                                end
                                else
                                begin
                                    wr_en = 1'b1;
                                    wr_addr = count_reg[IXW-1:0];
                                    wr_data = {key_reg, newent_reg};
                                    count_next = count_reg + CW'(1);
                                    o_status_next = ADD_OK;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                o_status_next = ADD_NONE;
                            end
                            CMD_READ:
                            begin
                                o_read_data_next = data_reg;
                            end
                            CMD_APPLY:
                            begin
                                if (held_valid_reg)
                                begin
                                    o_wv_next = 1'b1;
                                    o_kind_next = held_reg.kind - 2'd1;
                                    o_bank_next = held_reg.bank;
                                    o_addr_next = held_reg.addr;
                                    o_value_next = held_reg.new_val;
                                end
                            end
                        endcase
                    end
                end
                else if (!((cmd_reg == CMD_APPLY) && wr_hit && held_valid_reg && !out_free))
                begin
                    // a found write is held back one step so the final beat can carry last
                    if ((cmd_reg == CMD_APPLY) && wr_hit)
                    begin
                        if (held_valid_reg)
                        begin
                            o_wv_next = 1'b1;
                            o_kind_next = held_reg.kind - 2'd1;
                            o_bank_next = held_reg.bank;
                            o_addr_next = held_reg.addr;
                            o_value_next = held_reg.new_val;
                            o_last_next = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        held_next = e.ent;
                        held_valid_next = 1'b1;
                        found_next = found_reg + FOUND_W'(1);
                    end
                    if (more)
                    begin
                        rd_en = 1'b1;
                        idx_next = idx_reg + CW'(1);
                        eidx_next = idx_reg[IXW-1:0];
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg <= CMD_ADD;
            skip_reg <= 1'b0;
            badtype_reg <= 1'b0;
            idx_reg <= '0;
            count_reg <= '0;
            pend_reg <= 1'b0;
            found_reg <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg <= cmd_next;
            skip_reg <= skip_next;
            badtype_reg <= badtype_next;
            idx_reg <= idx_next;
            count_reg <= count_next;
            pend_reg <= pend_next;
            found_reg <= found_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        newent_reg <= newent_next;
        vaddr_reg <= vaddr_next;
        data_reg <= data_next;
        eidx_reg <= eidx_next;
        held_reg <= held_next;
        o_read_data_reg <= o_read_data_next;
        o_status_reg <= o_status_next;
        o_wv_reg <= o_wv_next;
        o_kind_reg <= o_kind_next;
        o_bank_reg <= o_bank_next;
        o_addr_reg <= o_addr_next;
        o_value_reg <= o_value_next;
        o_last_reg <= o_last_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = o_read_data_reg;
    assign add_status = o_status_reg;
    assign write_valid = o_wv_reg;
    assign write_kind = o_kind_reg;
    assign write_bank = o_bank_reg;
    assign write_addr = o_addr_reg;
    assign write_value = o_value_reg;
    assign last = o_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ({1'b0, eidx_reg} < {1'b0, count_reg}))
        else $error("evaluated entry beyond entry count");

    a_held_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> ((state_reg == S_SCAN) && (cmd_reg == CMD_APPLY)))
        else $error("held write outside a frame apply");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FOUND_W'(MAX_RESULTS))
        else $error("too many writes in one frame");

endmodule
